// ----- src/breakpoint_address_table_unit_macros.svh -----
// Assertion macros for the breakpoint address table unit
`ifndef BREAKPOINT_ADDRESS_TABLE_UNIT_MACROS_SVH
`define BREAKPOINT_ADDRESS_TABLE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BAT_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("breakpoint table check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define BAT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("breakpoint table check failed");

`endif

// ----- src/bat_pkg.sv -----
package bat_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int ADDR_W      = 16;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int COUNT_OUT_W = 5;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_CHECK  = 2'd3
  } bat_kind_t;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    logic              store;
    logic              shift;
  } bat_cmd_t;

endpackage

// ----- src/bat_cell.sv -----
module bat_cell
  import bat_pkg::*;
(
  input  logic              clk,
  input  bat_cmd_t          cmd,
  input  logic              slot_used,
  input  logic              slot_tail,
  input  logic [ADDR_W-1:0] next_entry,
  input  logic              found_in,
  output logic              found_out,
  output logic [ADDR_W-1:0] entry
);

  logic [ADDR_W-1:0] entry_r;
  logic [ADDR_W-1:0] entry_nxt;
  logic              match;

  always_comb begin
    match     = slot_used && (entry_r == cmd.address);
    found_out = found_in || match;
    entry_nxt = entry_r;
    if (cmd.store && slot_tail && !found_in) begin
      // append only when no used slot below already holds the address
      entry_nxt = cmd.address;
    end else if (cmd.shift && found_out && slot_used) begin
      // close the gap: take the neighbour's entry
      entry_nxt = next_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// ----- src/breakpoint_address_table_unit.sv -----
// Breakpoint address table unit.
// Input: raise start with in_kind, in_address and in_single_step; the request
// is taken at a rising edge where start is high and busy is low.
// Kinds: add, remove, clear all, check program counter.
// Output: out_valid strobes for one cycle with out_ok, out_halted and
// out_entry_count; the receiver cannot stall, so take the result that cycle.
// The accepting edge raises busy (req_r); out_valid is registered from busy.
// No request is taken while busy; busy is high for the one cycle in which
// the row of slot cells compares all entries against the address in
// parallel and updates itself (shift down on remove, append on add).
// Entries are packed from slot 0; only slots below the count are compared.
// Reset (rst_n low, synchronous): count and halted flag clear, no request is
// in flight, out_valid is low. The halted flag is sticky until reset.
module breakpoint_address_table_unit
  import bat_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             in_kind,
  input  logic [ADDR_W-1:0]      in_address,
  input  logic                   in_single_step,
  output logic                   out_valid,
  output logic                   out_ok,
  output logic                   out_halted,
  output logic [COUNT_OUT_W-1:0] out_entry_count
);

  logic                 req_r;
  bat_kind_t            kind_r;
  logic [ADDR_W-1:0]    addr_r;
  logic                 step_r;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  logic                 halted_r;
  logic                 halted_nxt;
  logic                 out_valid_r;
  logic                 out_ok_r;
  logic                 ok_nxt;
  logic                 full;
  logic                 any_match;
  logic [31:0]          count_ext;
  bat_cmd_t             cmd;

  logic [TABLE_DEPTH:0] found;
  logic [ADDR_W-1:0]    entries [TABLE_DEPTH];

  assign busy = req_r;
  assign full = (count_r == CNT_W'(TABLE_DEPTH));
  assign any_match = found[TABLE_DEPTH];
  assign found[0] = 1'b0;

  always_comb begin
    cmd.address = addr_r;
    cmd.store   = req_r && (kind_r == KIND_ADD) && !full;
    cmd.shift   = req_r && (kind_r == KIND_REMOVE);
  end

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      logic [ADDR_W-1:0] nbr;
      if (gi == TABLE_DEPTH - 1) begin : g_last
        assign nbr = entries[gi];
      end else begin : g_mid
        assign nbr = entries[gi+1];
      end
      bat_cell u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .slot_used  (count_r > CNT_W'(gi)),
        .slot_tail  (count_r == CNT_W'(gi)),
        .next_entry (nbr),
        .found_in   (found[gi]),
        .found_out  (found[gi+1]),
        .entry      (entries[gi])
      );
    end
  endgenerate

  always_comb begin
    count_nxt  = count_r;
    halted_nxt = halted_r;
    ok_nxt     = 1'b0;
    unique case (kind_r)
      KIND_ADD: begin
        if (!full) begin
          ok_nxt = 1'b1;
          if (!any_match) begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      KIND_REMOVE: begin
        if (any_match) begin
          ok_nxt    = 1'b1;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      KIND_CLEAR: begin
        ok_nxt    = 1'b1;
        count_nxt = '0;
      end
      KIND_CHECK: begin
        if (step_r || any_match) begin
          ok_nxt     = 1'b1;
          halted_nxt = 1'b1;
        end
      end
      default: begin
        ok_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r       <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
      halted_r    <= 1'b0;
    end else begin
      req_r       <= start && !req_r;
      out_valid_r <= req_r;
      if (req_r) begin
        count_r  <= count_nxt;
        halted_r <= halted_nxt;
      end
    end
  end

  // hold the request payload and the result flag
  always_ff @(posedge clk) begin
    if (start && !req_r) begin
      kind_r <= bat_kind_t'(in_kind);
      addr_r <= in_address;
      step_r <= in_single_step;
    end
    if (req_r) begin
      out_ok_r <= ok_nxt;
    end
  end

  assign count_ext       = 32'(count_r);
  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_halted      = halted_r;
  assign out_entry_count = count_ext[COUNT_OUT_W-1:0];

endmodule

// ----- src/bat_checker.sv -----
`include "breakpoint_address_table_unit_macros.svh"

module bat_checker
  import bat_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   start,
  input logic                   busy,
  input logic [1:0]             in_kind,
  input logic [ADDR_W-1:0]      in_address,
  input logic                   in_single_step,
  input logic                   out_valid,
  input logic                   out_ok,
  input logic                   out_halted,
  input logic [COUNT_OUT_W-1:0] out_entry_count
);

  `BAT_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `BAT_ASSERT_IMPLY(a_result_after_work, out_valid, $past(busy) && !busy)
  `BAT_ASSERT_IMPLY(a_halted_sticky, $past(rst_n), !$fell(out_halted))
  `BAT_ASSERT_IMPLY(a_count_moves_with_result, $past(rst_n) && !out_valid, $stable(out_entry_count))

endmodule

bind breakpoint_address_table_unit bat_checker u_bat_checker (.*);

// ----- sim/breakpoint_address_table_unit_checker.sv -----
module breakpoint_address_table_unit_checker
  import bat_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   busy,
  input  logic [1:0]             in_kind,
  input  logic [ADDR_W-1:0]      in_address,
  input  logic                   in_single_step,
  input  logic                   out_valid,
  input  logic                   out_ok,
  input  logic                   out_halted,
  input  logic [COUNT_OUT_W-1:0] out_entry_count,
  output int                     fail_count,
  output int                     pending_count
);

  typedef struct packed {
    logic                   ok;
    logic                   halted;
    logic [COUNT_OUT_W-1:0] entry_count;
  } table_reply_t;

  logic [ADDR_W-1:0] stored_addr [TABLE_DEPTH];
  int                stored_count;
  logic              halted_seen;
  table_reply_t      awaited_replies[$];

  initial begin
    fail_count    = 0;
    pending_count = 0;
    stored_count  = 0;
    halted_seen   = 1'b0;
  end

  task automatic predict_table_op(input bat_kind_t kind, input logic [ADDR_W-1:0] addr,
                                  input logic step);
    int           hit_slot;
    table_reply_t reply;
    hit_slot = -1;
    for (int i = 0; i < stored_count; i++) begin
      if (hit_slot < 0 && stored_addr[i] == addr) begin
        hit_slot = i;
      end
    end
    reply.ok = 1'b0;
    case (kind)
      KIND_ADD: begin
        if (stored_count < TABLE_DEPTH) begin
          if (hit_slot < 0) begin
            stored_addr[stored_count] = addr;
            stored_count++;
          end
          reply.ok = 1'b1;
        end
      end
      KIND_REMOVE: begin
        if (hit_slot >= 0) begin
          for (int i = hit_slot; i + 1 < stored_count; i++) begin
            stored_addr[i] = stored_addr[i + 1];
          end
          stored_count--;
          reply.ok = 1'b1;
        end
      end
      KIND_CLEAR: begin
        stored_count = 0;
        reply.ok     = 1'b1;
      end
      default: begin
        if (step || hit_slot >= 0) begin
          halted_seen = 1'b1;
          reply.ok    = 1'b1;
        end
      end
    endcase
    reply.halted      = halted_seen;
    reply.entry_count = stored_count[COUNT_OUT_W-1:0];
    awaited_replies.push_back(reply);
  endtask

  always @(posedge clk) begin
    table_reply_t want;
    if (!rst_n) begin
      stored_count = 0;
      halted_seen  = 1'b0;
      awaited_replies.delete();
    end else begin
      if (start && !busy) begin
        predict_table_op(bat_kind_t'(in_kind), in_address, in_single_step);
      end
      if (out_valid) begin
        if (awaited_replies.size() == 0) begin
          $error("result with no request outstanding");
          fail_count++;
        end else begin
          want = awaited_replies.pop_front();
          if (out_ok !== want.ok) begin
            $error("out_ok: expected %0d, actual %0d", want.ok, out_ok);
            fail_count++;
          end
          if (out_halted !== want.halted) begin
            $error("out_halted: expected %0d, actual %0d", want.halted, out_halted);
            fail_count++;
          end
          if (out_entry_count !== want.entry_count) begin
            $error("out_entry_count: expected %0d, actual %0d",
                   want.entry_count, out_entry_count);
            fail_count++;
          end
        end
      end
    end
    pending_count = awaited_replies.size();
  end

endmodule

// ----- sim/breakpoint_address_table_unit_test.sv -----
module breakpoint_address_table_unit_test;
  import bat_pkg::*;

  localparam int RANDOM_REQUESTS = 800;
  localparam int HOT_ADDRS       = 20;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [1:0]             in_kind = '0;
  logic [ADDR_W-1:0]      in_address = '0;
  logic                   in_single_step = 1'b0;
  logic                   out_valid;
  logic                   out_ok;
  logic                   out_halted;
  logic [COUNT_OUT_W-1:0] out_entry_count;
  int                     fail_count;
  int                     pending_count;

  logic [ADDR_W-1:0] hot_addr [HOT_ADDRS];
  int                burst_left = 0;
  bit                gaps_on = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  breakpoint_address_table_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_address      (in_address),
    .in_single_step  (in_single_step),
    .out_valid       (out_valid),
    .out_ok          (out_ok),
    .out_halted      (out_halted),
    .out_entry_count (out_entry_count)
  );

  breakpoint_address_table_unit_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_address      (in_address),
    .in_single_step  (in_single_step),
    .out_valid       (out_valid),
    .out_ok          (out_ok),
    .out_halted      (out_halted),
    .out_entry_count (out_entry_count),
    .fail_count      (fail_count),
    .pending_count   (pending_count)
  );

  task automatic issue_request(input bat_kind_t kind, input logic [ADDR_W-1:0] addr,
                               input logic step);
    int gap;
    @(negedge clk);
    start          <= 1'b1;
    in_kind        <= kind;
    in_address     <= addr;
    in_single_step <= step;
    // hold the request until the block takes it
    do @(posedge clk); while (busy);
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(24, 1);
        gap        = $urandom_range(6, 1);
        @(negedge clk);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic refresh_hot_addrs();
    foreach (hot_addr[i]) hot_addr[i] = ADDR_W'($urandom_range(16'hFFFF));
  endtask

  initial begin
    int                pick;
    bat_kind_t         kind;
    logic [ADDR_W-1:0] addr;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    issue_request(KIND_CHECK, 16'h0000, 1'b0);
    issue_request(KIND_ADD, 16'h0000, 1'b0);
    issue_request(KIND_ADD, 16'hFFFF, 1'b0);
    issue_request(KIND_ADD, 16'hFFFF, 1'b1);
    issue_request(KIND_CHECK, 16'hFFFF, 1'b0);
    issue_request(KIND_REMOVE, 16'h1234, 1'b0);
    issue_request(KIND_REMOVE, 16'h0000, 1'b0);
    for (int i = 1; i < TABLE_DEPTH; i++) begin
      issue_request(KIND_ADD, ADDR_W'(16'h1000 + i * 16'h0111), 1'b0);
    end
    issue_request(KIND_ADD, 16'hFFFF, 1'b0);
    issue_request(KIND_ADD, 16'hA5A5, 1'b0);
    issue_request(KIND_REMOVE, ADDR_W'(16'h1000 + 7 * 16'h0111), 1'b0);
    issue_request(KIND_CLEAR, 16'h5A5A, 1'b1);
    issue_request(KIND_CHECK, 16'hFFFF, 1'b0);
    issue_request(KIND_CHECK, 16'h0000, 1'b1);

    refresh_hot_addrs();
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 200 == 199) refresh_hot_addrs();
      gaps_on = !(n >= 300 && n < 450);
      pick = $urandom_range(99);
      if (pick < 38) kind = KIND_ADD;
      else if (pick < 62) kind = KIND_REMOVE;
      else if (pick < 96) kind = KIND_CHECK;
      else kind = KIND_CLEAR;
      if ($urandom_range(9) == 0) addr = ADDR_W'($urandom_range(16'hFFFF));
      else addr = hot_addr[$urandom_range(HOT_ADDRS - 1)];
      issue_request(kind, addr, $urandom_range(9) == 0);
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    // allow a stray late result to surface
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("Verification failed");
    $finish;
  end

endmodule
